[rtl/hots_pkg.sv]
// Shared types, constants and the hold-band table for the heater on-time scheduler.
package hots_pkg;

	localparam int SP_W    = 15;
	localparam int MEAS_W  = 16;
	localparam int ERR_W   = 18;
	localparam int MAG_W   = 17;
	localparam int ON_W    = 16;
	localparam int LIM_W   = 12;
	localparam int DEAD_W  = 11;
	localparam int BAND_W  = 14;
	localparam int IDX_W   = 3;
	localparam int CFG_W   = 16;
	localparam int IN_TDATA_W = 32;

	localparam logic [IDX_W-1:0] REG_OVERSHOOT_LIMIT = 3'd0;
	localparam logic [IDX_W-1:0] REG_DEAD_BAND       = 3'd1;
	localparam logic [IDX_W-1:0] REG_NEAR_BAND       = 3'd2;
	localparam logic [IDX_W-1:0] REG_MID_BAND        = 3'd3;
	localparam logic [IDX_W-1:0] REG_FAR_BAND        = 3'd4;
	localparam logic [IDX_W-1:0] REG_FAR_POWER       = 3'd5;
	localparam logic [IDX_W-1:0] REG_MID_POWER       = 3'd6;
	localparam logic [IDX_W-1:0] REG_NEAR_POWER      = 3'd7;

	localparam logic signed [LIM_W-1:0] RST_OVERSHOOT_LIMIT = -12'sd40;
	localparam logic [DEAD_W-1:0] RST_DEAD_BAND  = 11'd10;
	localparam logic [BAND_W-1:0] RST_NEAR_BAND  = 14'd500;
	localparam logic [BAND_W-1:0] RST_MID_BAND   = 14'd1000;
	localparam logic [BAND_W-1:0] RST_FAR_BAND   = 14'd4000;
	localparam logic [ON_W-1:0]   RST_FAR_POWER  = 16'd1400;
	localparam logic [ON_W-1:0]   RST_MID_POWER  = 16'd350;
	localparam logic [ON_W-1:0]   RST_NEAR_POWER = 16'd250;

	localparam logic [SP_W-1:0] SP_HALVE_BELOW = 15'd17000;
	localparam logic [SP_W-1:0] SP_ADD20_BELOW = 15'd23500;
	localparam logic [SP_W-1:0] SP_ADD60_BELOW = 15'd24500;
	localparam logic [SP_W-1:0] SP_NEAR_BONUS_ABOVE = 15'd23500;

	localparam logic [ON_W-1:0] STEP_SMALL = 16'd20;
	localparam logic [ON_W-1:0] STEP_LARGE = 16'd60;
	localparam logic [ON_W-1:0] ON_MAX     = 16'hFFFF;

	typedef struct packed {
		logic signed [LIM_W-1:0] overshoot_limit;
		logic [DEAD_W-1:0]       dead_band;
		logic [BAND_W-1:0]       near_band;
		logic [BAND_W-1:0]       mid_band;
		logic [BAND_W-1:0]       far_band;
		logic [ON_W-1:0]         far_power;
		logic [ON_W-1:0]         mid_power;
		logic [ON_W-1:0]         near_power;
	} cfg_t;

	typedef struct packed {
		logic [ON_W-1:0] on_time;
		logic [ON_W-1:0] held_on_time;
		logic            overshoot;
	} step_t;

	function automatic logic [ON_W-1:0] sat_add(input logic [ON_W-1:0] a,
			input logic [ON_W-1:0] b);
		logic [ON_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[ON_W] ? ON_MAX : s[ON_W-1:0];
	endfunction

	function automatic logic [ON_W-1:0] hold_on_time(input logic [SP_W-1:0] sp);
		logic [ON_W-1:0] v;
		if (sp < 15'd5500)       v = 16'd100;
		else if (sp < 15'd8500)  v = 16'd120;
		else if (sp < 15'd12500) v = 16'd140;
		else if (sp < 15'd18500) v = 16'd160;
		else if (sp < 15'd22500) v = 16'd180;
		else if (sp < 15'd23500) v = 16'd200;
		else                     v = 16'd240;
		return v;
	endfunction

endpackage

[rtl/heater_on_time_scheduler_unit.sv]
// Top level of the heater on-time scheduler: stream ports, configuration and state.
// A measurement is held in the input register until its result is loaded into the output register.
// Throughput: one measurement per cycle while the output is not stalled, limited by the single decision stage that
// updates the on-time state as each result is loaded into the output register.
// The input register accepts a new transfer while a finished result waits to be taken, provided it is empty.
// Reset (arst_n low, asynchronous) loads the register defaults and clears both on-times.
module heater_on_time_scheduler_unit
	import hots_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,   // set_point[14:0], measured[30:15], zero[31]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [ON_W-1:0]       m_tdata,   // on_time_ms[15:0]
	output logic                  m_tuser,   // overshoot[0]
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	cfg_t                     cfg_q;
	logic                     valid_s1;
	logic [SP_W-1:0]          set_point_s1;
	logic signed [MEAS_W-1:0] measured_s1;
	logic [ON_W-1:0]          on_time_q;
	logic [ON_W-1:0]          held_q;
	logic                     out_valid_q;
	logic [ON_W-1:0]          out_on_time_q;
	logic                     out_flag_q;
	logic                     adv;
	step_t                    nxt;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || adv;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_on_time_q;
	assign m_tuser   = out_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.overshoot_limit <= RST_OVERSHOOT_LIMIT;
			cfg_q.dead_band       <= RST_DEAD_BAND;
			cfg_q.near_band       <= RST_NEAR_BAND;
			cfg_q.mid_band        <= RST_MID_BAND;
			cfg_q.far_band        <= RST_FAR_BAND;
			cfg_q.far_power       <= RST_FAR_POWER;
			cfg_q.mid_power       <= RST_MID_POWER;
			cfg_q.near_power      <= RST_NEAR_POWER;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_OVERSHOOT_LIMIT: cfg_q.overshoot_limit <= $signed(cfg_data[LIM_W-1:0]);
				REG_DEAD_BAND:       cfg_q.dead_band  <= cfg_data[DEAD_W-1:0];
				REG_NEAR_BAND:       cfg_q.near_band  <= cfg_data[BAND_W-1:0];
				REG_MID_BAND:        cfg_q.mid_band   <= cfg_data[BAND_W-1:0];
				REG_FAR_BAND:        cfg_q.far_band   <= cfg_data[BAND_W-1:0];
				REG_FAR_POWER:       cfg_q.far_power  <= cfg_data;
				REG_MID_POWER:       cfg_q.mid_power  <= cfg_data;
				REG_NEAR_POWER:      cfg_q.near_power <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			set_point_s1 <= s_tdata[SP_W-1:0];
			measured_s1  <= $signed(s_tdata[SP_W+MEAS_W-1:SP_W]);
		end
	end

	hots_calc u_calc (
		.cfg          (cfg_q),
		.set_point    (set_point_s1),
		.measured     (measured_s1),
		.on_time      (on_time_q),
		.held_on_time (held_q),
		.nxt          (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_time_q     <= '0;
			held_q        <= '0;
			out_valid_q   <= 1'b0;
			out_on_time_q <= '0;
			out_flag_q    <= 1'b0;
		end else begin
			if (adv) begin
				on_time_q     <= nxt.on_time;
				held_q        <= nxt.held_on_time;
				out_valid_q   <= 1'b1;
				out_on_time_q <= nxt.on_time;
				out_flag_q    <= nxt.overshoot;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The result on the output always equals the current on-time state.
	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata == on_time_q)
		else $error("output on-time differs from state");

	// State changes only when an item moves into the output register.
	a_state_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(on_time_q) && $stable(held_q))
		else $error("state changed without a transfer");

	// Input is held off only while both stages are full and the output is stalled.
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && out_valid_q && !m_tready)
		else $error("input stalled needlessly");

	// An advancing item always produces a result in the next cycle.
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("result lost after advance");

endmodule

[rtl/hots_calc.sv]
// Decision logic that computes the next on-time, held on-time and overshoot flag.
module hots_calc
	import hots_pkg::*;
(
	input  cfg_t                     cfg,
	input  logic [SP_W-1:0]          set_point,
	input  logic signed [MEAS_W-1:0] measured,
	input  logic [ON_W-1:0]          on_time,
	input  logic [ON_W-1:0]          held_on_time,
	output step_t                    nxt
);

	logic signed [ERR_W-1:0] err;
	logic signed [ERR_W-1:0] neg_err;
	logic signed [ERR_W-1:0] lim_ext;
	logic [MAG_W-1:0]        mag;

	assign err     = $signed({{(ERR_W-SP_W){1'b0}}, set_point})
	                 - $signed({{(ERR_W-MEAS_W){measured[MEAS_W-1]}}, measured});
	assign neg_err = -err;
	assign mag     = err[ERR_W-1] ? neg_err[MAG_W-1:0] : err[MAG_W-1:0];
	assign lim_ext = $signed({{(ERR_W-LIM_W){cfg.overshoot_limit[LIM_W-1]}},
	                          cfg.overshoot_limit});

	always_comb begin
		nxt.on_time      = on_time;
		nxt.held_on_time = held_on_time;
		nxt.overshoot    = 1'b0;
		if (err < lim_ext) begin
			nxt.overshoot = 1'b1;
			if (set_point < SP_HALVE_BELOW) begin
				nxt.on_time = {1'b0, held_on_time[ON_W-1:1]};
			end else if (set_point < SP_ADD20_BELOW) begin
				nxt.on_time = sat_add(on_time, STEP_SMALL);
			end else if (set_point < SP_ADD60_BELOW) begin
				nxt.on_time = sat_add(on_time, STEP_LARGE);
			end
		end else if (mag > {{(MAG_W-BAND_W){1'b0}}, cfg.far_band}) begin
			nxt.on_time = cfg.far_power;
		end else if (mag > {{(MAG_W-BAND_W){1'b0}}, cfg.mid_band}) begin
			nxt.on_time = cfg.mid_power;
		end else if (mag > {{(MAG_W-BAND_W){1'b0}}, cfg.near_band}) begin
			if (set_point > SP_NEAR_BONUS_ABOVE) begin
				nxt.on_time = sat_add(cfg.near_power, STEP_SMALL);
			end else begin
				nxt.on_time = cfg.near_power;
			end
		end else if (mag > {{(MAG_W-DEAD_W){1'b0}}, cfg.dead_band}) begin
			nxt.on_time      = hold_on_time(set_point);
			nxt.held_on_time = hold_on_time(set_point);
		end
	end

endmodule

[sim/heater_on_time_scheduler_checker.sv]
// Checker for the heater on-time scheduler: watches all channels, predicts each result and compares.
module heater_on_time_scheduler_checker
	import hots_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [ON_W-1:0]       m_tdata,
	input  logic                  m_tuser,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	output int                    fail_count,
	output int                    pending
);

	localparam int HALVE_SP_BELOW  = 17000;
	localparam int ADD20_SP_BELOW  = 23500;
	localparam int ADD60_SP_BELOW  = 24500;
	localparam int BONUS_SP_ABOVE  = 23500;
	localparam int SMALL_STEP_MS   = 20;
	localparam int LARGE_STEP_MS   = 60;
	localparam int ON_TIME_CEILING = 65535;

	typedef struct packed {
		logic [ON_W-1:0] on_time_ms;
		logic            overshoot;
	} heat_result_t;

	heat_result_t due_results[$];
	heat_result_t want;

	logic signed [LIM_W-1:0] limit_q;
	logic [DEAD_W-1:0]       dead_q;
	logic [BAND_W-1:0]       near_q;
	logic [BAND_W-1:0]       mid_q;
	logic [BAND_W-1:0]       far_q;
	logic [ON_W-1:0]         far_pwr;
	logic [ON_W-1:0]         mid_pwr;
	logic [ON_W-1:0]         near_pwr;
	logic [ON_W-1:0]         on_time_q;
	logic [ON_W-1:0]         held_q;

	function automatic logic [ON_W-1:0] plus_clamped(input logic [ON_W-1:0] base, input int step);
		int sum;
		sum = int'(base) + step;
		if (sum > ON_TIME_CEILING)
			sum = ON_TIME_CEILING;
		return sum[ON_W-1:0];
	endfunction

	function automatic logic [ON_W-1:0] band_on_time(input logic [SP_W-1:0] sp);
		int sp_edges[6] = '{5500, 8500, 12500, 18500, 22500, 23500};
		for (int i = 0; i < 6; i++) begin
			if (int'(sp) < sp_edges[i])
				return ON_W'(100 + 20 * i);
		end
		return ON_W'(240);
	endfunction

	task automatic schedule_step(input logic [IN_TDATA_W-1:0] data);
		logic [SP_W-1:0]          sp;
		logic signed [MEAS_W-1:0] meas;
		int                       err;
		int                       mag;
		heat_result_t             r;
		sp = data[SP_W-1:0];
		meas = data[SP_W +: MEAS_W];
		err = int'(sp) - int'(meas);
		mag = (err < 0) ? -err : err;
		r.overshoot = 1'b0;
		if (err < int'(limit_q)) begin
			r.overshoot = 1'b1;
			if (int'(sp) < HALVE_SP_BELOW)
				on_time_q = held_q >> 1;
			else if (int'(sp) < ADD20_SP_BELOW)
				on_time_q = plus_clamped(on_time_q, SMALL_STEP_MS);
			else if (int'(sp) < ADD60_SP_BELOW)
				on_time_q = plus_clamped(on_time_q, LARGE_STEP_MS);
		end else if (mag > int'(far_q)) begin
			on_time_q = far_pwr;
		end else if (mag > int'(mid_q)) begin
			on_time_q = mid_pwr;
		end else if (mag > int'(near_q)) begin
			on_time_q = near_pwr;
			if (int'(sp) > BONUS_SP_ABOVE)
				on_time_q = plus_clamped(on_time_q, SMALL_STEP_MS);
		end else if (mag > int'(dead_q)) begin
			on_time_q = band_on_time(sp);
			held_q = on_time_q;
		end
		r.on_time_ms = on_time_q;
		due_results.push_back(r);
	endtask

	task automatic write_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		case (idx)
			REG_OVERSHOOT_LIMIT: limit_q = data[LIM_W-1:0];
			REG_DEAD_BAND:       dead_q = data[DEAD_W-1:0];
			REG_NEAR_BAND:       near_q = data[BAND_W-1:0];
			REG_MID_BAND:        mid_q = data[BAND_W-1:0];
			REG_FAR_BAND:        far_q = data[BAND_W-1:0];
			REG_FAR_POWER:       far_pwr = data[ON_W-1:0];
			REG_MID_POWER:       mid_pwr = data[ON_W-1:0];
			REG_NEAR_POWER:      near_pwr = data[ON_W-1:0];
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q = -12'sd40;
			dead_q = 11'd10;
			near_q = 14'd500;
			mid_q = 14'd1000;
			far_q = 14'd4000;
			far_pwr = 16'd1400;
			mid_pwr = 16'd350;
			near_pwr = 16'd250;
			on_time_q = '0;
			held_q = '0;
			due_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected result transfer, on_time_ms %0d overshoot %0b",
						$time, m_tdata, m_tuser);
					fail_count++;
				end else begin
					want = due_results.pop_front();
					if (m_tdata !== want.on_time_ms) begin
						$display("%0t: on_time_ms expected %0d, actual %0d",
							$time, want.on_time_ms, m_tdata);
						fail_count++;
					end
					if (m_tuser !== want.overshoot) begin
						$display("%0t: overshoot expected %0b, actual %0b",
							$time, want.overshoot, m_tuser);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready)
				write_register(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				schedule_step(s_tdata);
			pending = due_results.size();
		end
	end

endmodule

[sim/heater_on_time_scheduler_unit_test.sv]
// Testbench top for the heater on-time scheduler: clock, reset, stimulus, watchdog and verdict.
module heater_on_time_scheduler_unit_test;
	import hots_pkg::*;

	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int ITEMS_PER_PHASE = 250;
	localparam int PHASES          = 7;
	localparam int STALL_AT        = 700;
	localparam int STALL_CYCLES    = 400;
	localparam int DIRECTED_ITEMS  = 26;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [ON_W-1:0]       m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [IDX_W-1:0]      cfg_index;
	logic [CFG_W-1:0]      cfg_data;

	int fail_count;
	int pending;
	int idle_cycles;
	int sent;
	int results_taken;
	int cfg_shadow[8];

	heater_on_time_scheduler_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	heater_on_time_scheduler_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.pending(pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Every fourth stretch of items runs with no idling at all.
	function automatic int draw_gap(input int n);
		if ((n / 120) % 4 == 3)
			return 0;
		return int'($urandom_range(0, 5));
	endfunction

	task automatic send_meas(input int sp, input int meas);
		int gap;
		gap = draw_gap(sent);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, meas[MEAS_W-1:0], sp[SP_W-1:0]};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent++;
	endtask

	// Half of the measurements are aimed at the band edges of the current setting.
	task automatic send_random();
		int sp;
		int err;
		int meas;
		int pick;
		int targets[10];
		if ($urandom_range(0, 19) == 0)
			sp = int'($urandom_range(30001, 32767));
		else
			sp = int'($urandom_range(0, 30000));
		pick = int'($urandom_range(0, 9));
		if (pick < 5) begin
			targets = '{cfg_shadow[REG_OVERSHOOT_LIMIT], cfg_shadow[REG_DEAD_BAND],
				-cfg_shadow[REG_DEAD_BAND], cfg_shadow[REG_NEAR_BAND],
				-cfg_shadow[REG_NEAR_BAND], cfg_shadow[REG_MID_BAND],
				-cfg_shadow[REG_MID_BAND], cfg_shadow[REG_FAR_BAND],
				-cfg_shadow[REG_FAR_BAND], 0};
			err = targets[$urandom_range(0, 9)] + int'($urandom_range(0, 6)) - 3;
			meas = sp - err;
		end else if (pick < 9) begin
			meas = int'($urandom_range(0, 34000)) - 4000;
		end else begin
			meas = int'($urandom_range(0, 65535)) - 32768;
		end
		if (meas > 32767)
			meas = 32767;
		if (meas < -32768)
			meas = -32768;
		send_meas(sp, meas);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_shadow[idx] = value;
	endtask

	task automatic apply_config(input int vals[8]);
		settle();
		write_reg(REG_OVERSHOOT_LIMIT, vals[REG_OVERSHOOT_LIMIT]);
		write_reg(REG_DEAD_BAND, vals[REG_DEAD_BAND]);
		write_reg(REG_NEAR_BAND, vals[REG_NEAR_BAND]);
		write_reg(REG_MID_BAND, vals[REG_MID_BAND]);
		write_reg(REG_FAR_BAND, vals[REG_FAR_BAND]);
		write_reg(REG_FAR_POWER, vals[REG_FAR_POWER]);
		write_reg(REG_MID_POWER, vals[REG_MID_POWER]);
		write_reg(REG_NEAR_POWER, vals[REG_NEAR_POWER]);
		cfg_valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (results_taken == STALL_AT) begin
				m_tready <= 1'b0;
				repeat (STALL_CYCLES) @(negedge clk);
			end
			gap = draw_gap(results_taken + 60);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
			results_taken++;
		end
	end

	initial begin
		int dir_sp[DIRECTED_ITEMS] = '{0, 5000, 5000, 5499, 5500, 8500, 12500, 18500, 22500,
			23500, 10000, 10000, 20000, 23500, 24500, 23500, 23500, 23501, 20000, 20000,
			20000, 20000, 32767, 0, 30000, 32767};
		int dir_meas[DIRECTED_ITEMS] = '{0, 4990, 4989, 5479, 5480, 8480, 12480, 18480, 22480,
			23480, 10040, 10041, 20041, 23541, 24541, 23000, 22999, 23000, 19000, 18999,
			16000, 15999, -32768, 32767, -4000, 32767};
		int vals[8];
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		cfg_shadow = '{-40, 10, 500, 1000, 4000, 1400, 350, 250};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ITEMS; i++)
			send_meas(dir_sp[i], dir_meas[i]);

		// Saturating additions at the top of the on-time range.
		vals = '{-40, 10, 500, 1000, 4000, 65535, 350, 65535};
		apply_config(vals);
		send_meas(20000, 15000);
		send_meas(20000, 20100);
		send_meas(24000, 24100);
		send_meas(24000, 23400);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: vals = '{-2000, 0, 0, 0, 0, 0, 0, 0};
				1: vals = '{0, 2000, 10000, 10000, 10000, 65535, 65535, 65535};
				2: vals = '{-40, 10, 500, 1000, 4000, 1400, 350, 250};
				3: vals = '{-int'($urandom_range(0, 200)), 15, 300, 2500, 6000,
					int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535)),
					int'($urandom_range(65000, 65535))};
				default: vals = '{-int'($urandom_range(0, 2000)), int'($urandom_range(0, 2000)),
					int'($urandom_range(0, 10000)), int'($urandom_range(0, 10000)),
					int'($urandom_range(0, 10000)), int'($urandom_range(0, 65535)),
					int'($urandom_range(0, 65535)), int'($urandom_range(0, 65535))};
			endcase
			apply_config(vals);
			for (int k = 0; k < ITEMS_PER_PHASE; k++)
				send_random();
		end

		settle();
		repeat (6) @(negedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
